FILE: hdl/cpmd_pkg.sv
// Shared constants and types for the closest pair minimum distance block.
// No dependencies; imported by cpmd_dist_unit and closest_pair_min_distance.
package cpmd_pkg;

  localparam int unsigned MAX_POINTS = 1024;
  localparam int unsigned CoordW     = 31;
  localparam int unsigned SqW        = 2 * CoordW;
  localparam int unsigned DistW      = SqW + 1;
  localparam int unsigned EntryW     = 2 * CoordW;
  localparam int unsigned AddrW      = $clog2(MAX_POINTS);
  localparam int unsigned CntW       = $clog2(MAX_POINTS + 1);

  typedef struct packed {
    logic busy;
    logic dist_vld;
  } dist_stat_t;

endpackage

FILE: hdl/cpmd_dist_unit.sv
// Pipelined squared Euclidean distance unit: |dx|,|dy|, then squares, then sum.
// Depends on cpmd_pkg.
module cpmd_dist_unit import cpmd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic signed [CoordW-1:0] ref_x_i,
  input  logic signed [CoordW-1:0] ref_y_i,
  input  logic        [EntryW-1:0] entry_i,
  output dist_stat_t               stat_o,
  output logic        [DistW-1:0]  dist_o
);

  logic signed [CoordW-1:0] sx, sy;
  logic signed [CoordW:0]   dx, dy;
  logic        [CoordW-1:0] ax_d, ay_d;
  logic        [CoordW-1:0] ax_q, ay_q;
  logic        [SqW-1:0]    sqx_d, sqy_d;
  logic        [SqW-1:0]    sqx_q, sqy_q;
  logic                     v1_q, v2_q;

  assign sx = entry_i[CoordW-1:0];
  assign sy = entry_i[EntryW-1:CoordW];

  always_comb begin
    dx    = {ref_x_i[CoordW-1], ref_x_i} - {sx[CoordW-1], sx};
    dy    = {ref_y_i[CoordW-1], ref_y_i} - {sy[CoordW-1], sy};
    ax_d  = dx[CoordW] ? CoordW'(-dx) : dx[CoordW-1:0];
    ay_d  = dy[CoordW] ? CoordW'(-dy) : dy[CoordW-1:0];
    sqx_d = SqW'(ax_q) * SqW'(ax_q);
    sqy_d = SqW'(ay_q) * SqW'(ay_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q  <= ax_d;
    ay_q  <= ay_d;
    sqx_q <= sqx_d;
    sqy_q <= sqy_d;
  end

  assign dist_o          = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign stat_o.busy     = v1_q | v2_q;
  assign stat_o.dist_vld = v2_q;

endmodule

FILE: hdl/closest_pair_min_distance.sv
// Channel  | Direction | Handshake               | Payload
// request  | in        | in_valid_i / in_stall_o | px_i, py_i, last_point_i
// result   | out       | out_valid_o/out_stall_i | min_sq_dist_o, pair_found_o, overflowed_o
//
// A point arriving with n points stored holds in_stall_o high while they are read,
// one per cycle, and the pipeline drains (none when n is zero or the store is full).
// A last point then passes FINISH, which loads the result register and clears the
// set, waiting while the previous result is stalled. No clearing pass after reset.
// The result register holds while out_stall_i is high; a new set may proceed.
// Depends on cpmd_pkg and cpmd_dist_unit.
module closest_pair_min_distance import cpmd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [CoordW-1:0] px_i,
  input  logic signed [CoordW-1:0] py_i,
  input  logic                     last_point_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic        [DistW-1:0]  min_sq_dist_o,
  output logic                     pair_found_o,
  output logic                     overflowed_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  localparam logic [CntW-1:0]  CntMax   = CntW'(MAX_POINTS);
  localparam logic [DistW-1:0] DistOnes = '1;

  state_e                    state_q;
  logic        [EntryW-1:0]  mem_q [MAX_POINTS];
  logic        [EntryW-1:0]  rd_data_q;
  logic                      rd_vld_q;
  logic        [AddrW-1:0]   rd_addr_q;
  logic        [AddrW-1:0]   scan_last_q;
  logic        [CntW-1:0]    cnt_q;
  logic        [DistW-1:0]   best_q;
  logic                      ovf_q;
  logic signed [CoordW-1:0]  px_q, py_q;
  logic                      last_q;
  logic                      out_vld_q;
  logic        [DistW-1:0]   out_dist_q;
  logic                      out_pair_q, out_ovf_q;
  logic                      accept;
  logic                      wr_en, rd_en;
  logic                      load_res;
  dist_stat_t                dstat;
  logic        [DistW-1:0]   pair_dist;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign wr_en      = accept && (cnt_q != CntMax);
  assign rd_en      = (state_q == ST_SCAN);
  assign load_res   = (state_q == ST_FINISH) && (!out_vld_q || !out_stall_i);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cnt_q[AddrW-1:0]] <= {py_i, px_i};
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr_q];
    end
  end

  cpmd_dist_unit u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rd_vld_q),
    .ref_x_i (px_q),
    .ref_y_i (py_q),
    .entry_i (rd_data_q),
    .stat_o  (dstat),
    .dist_o  (pair_dist)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q   <= px_i;
      py_q   <= py_i;
      last_q <= last_point_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_vld_q    <= 1'b0;
      rd_addr_q   <= '0;
      scan_last_q <= '0;
      cnt_q       <= '0;
      best_q      <= DistOnes;
      ovf_q       <= 1'b0;
      out_vld_q   <= 1'b0;
      out_dist_q  <= DistOnes;
      out_pair_q  <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      if (load_res) begin
        out_vld_q  <= 1'b1;
        out_dist_q <= best_q;
        out_pair_q <= (cnt_q >= CntW'(2));
        out_ovf_q  <= ovf_q;
        best_q     <= DistOnes;
      end else begin
        if (out_vld_q && !out_stall_i) begin
          out_vld_q <= 1'b0;
        end
        if (dstat.dist_vld && (pair_dist < best_q)) begin
          best_q <= pair_dist;
        end
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (cnt_q == CntMax) begin
              ovf_q   <= 1'b1;
              state_q <= last_point_i ? ST_FINISH : ST_IDLE;
            end else begin
              cnt_q <= cnt_q + 1'b1;
              if (cnt_q == '0) begin
                state_q <= last_point_i ? ST_FINISH : ST_IDLE;
              end else begin
                rd_addr_q   <= '0;
                scan_last_q <= AddrW'(cnt_q - 1'b1);
                state_q     <= ST_SCAN;
              end
            end
          end
        end
        ST_SCAN: begin
          rd_addr_q <= rd_addr_q + 1'b1;
          if (rd_addr_q == scan_last_q) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!rd_vld_q && !dstat.busy) begin
            state_q <= last_q ? ST_FINISH : ST_IDLE;
          end
        end
        ST_FINISH: begin
          if (load_res) begin
            cnt_q   <= '0;
            ovf_q   <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_vld_q;
  assign min_sq_dist_o = out_dist_q;
  assign pair_found_o  = out_pair_q;
  assign overflowed_o  = out_ovf_q;

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!rd_vld_q && !dstat.busy))
    else $error("distance pipeline active while idle");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax)
    else $error("point count beyond store depth");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (rd_addr_q <= scan_last_q
      && AddrW'(cnt_q - CntW'(2)) == scan_last_q))
    else $error("scan address beyond stored points");

  a_clear_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q) == ST_FINISH && state_q == ST_IDLE) |-> (cnt_q == '0 && best_q == DistOnes
      && out_vld_q))
    else $error("set not cleared when result loaded");

endmodule
